// ===== src/tgd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared types and constants for the turning-grille decoder.
// ----------------------------------------------------------------------------
package tgd_pkg;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int GRID_W = 5;
    localparam int CMD_W  = 2;

    // Default for the largest grille edge
    localparam int MAX_SIZE_DEFAULT = 16;

    // Register reset values
    localparam logic [GRID_W-1:0] GRID_RESET      = 5'd4;
    localparam logic [CHAR_W-1:0] OPEN_MARK_RESET = 8'd79;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_GRID_SIZE = 1'b0;
    localparam logic REG_OPEN_MARK = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_MASK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_LETTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READOUT     = 2'd2;

    // Operation handed from front to back
    typedef enum logic [1:0] {
        OP_MASK,
        OP_LETTER,
        OP_READ
    } op_kind_t;

    // Bits of a queued operation besides the two addresses:
    // kind, data byte, hole bit, last flag
    localparam int OP_FIXED_W = 2 + CHAR_W + 1 + 1;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // Front sequencer: geometry update after reset or a grid_size write
    typedef enum logic [2:0] {
        RS_SIZE,
        RS_AREA,
        RS_FIT,
        RS_DIV,
        RS_RUN
    } front_state_t;

    // Back sequencer
    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/tgd_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_cmd_if
// Command channel: valid/ready handshake carrying cmd and cell_char.
// ----------------------------------------------------------------------------
interface tgd_cmd_if
    import tgd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] cell_char;

    modport source (output valid, output cmd, output cell_char, input ready);
    modport sink   (input valid, input cmd, input cell_char, output ready);
endinterface

`default_nettype wire

// ===== src/tgd_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_res_if
// Result channel: valid/ready handshake carrying one decoded position.
// ----------------------------------------------------------------------------
interface tgd_res_if
    import tgd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] letter;
    logic              letter_valid;
    logic              done_res;

    modport source (output valid, output letter, output letter_valid, output done_res,
                    input ready);
    modport sink   (input valid, input letter, input letter_valid, input done_res,
                    output ready);
endinterface

`default_nettype wire

// ===== src/tgd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_ram
// Generic single-port RAM, write-first not guaranteed, registered read.
// ----------------------------------------------------------------------------
module tgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tgd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module tgd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_word,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_word,
    output logic                  empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_word = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/tgd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_front
// Accepts command words, keeps the load and readout counters, works out
// the rotated mask address and queues one operation for each defined command.
// ----------------------------------------------------------------------------
module tgd_front
    import tgd_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEFAULT,
    localparam int CELLS = MAX_SIZE * MAX_SIZE,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int OPW = 2 * AW + OP_FIXED_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tgd_cmd_if.sink                cmd_ch,
    input  wire logic [GRID_W-1:0] grid_size,
    input  wire logic [CHAR_W-1:0] open_mark,
    input  wire logic              grid_write,
    input  wire logic              q_full,
    output logic                   q_push,
    output logic      [OPW-1:0]    q_word
);

    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int TW = $clog2(CELLS + 1);

    typedef struct packed {
        op_kind_t          kind;
        logic [AW-1:0]     hole_addr;
        logic [AW-1:0]     letter_addr;
        logic [CHAR_W-1:0] data;
        logic              hole_bit;
        logic              last;
    } op_t;

    front_state_t  state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [TW-1:0] total_reg, total_next;
    logic [AW-1:0] mask_pos_reg, mask_pos_next;
    logic [AW-1:0] letter_pos_reg, letter_pos_next;
    logic [AW-1:0] rd_pos_reg, rd_pos_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [IW-1:0] row_reg, row_next;
    logic [IW-1:0] col_reg, col_next;
    logic [1:0]    rot_reg, rot_next;

    logic          accept;
    logic [IW-1:0] nm1, mi, mj;
    logic [AW-1:0] hole_idx;
    logic [AW-1:0] mask_eff, letter_eff, rd_eff;
    logic          rd_wrap, mask_wrap, letter_wrap, col_wrap;
    op_t           op;

    assign cmd_ch.ready = (state_reg == RS_RUN) && !q_full;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign q_word       = op;

    // Rotated mask coordinates for the current readout position
    assign nm1 = IW'(n_reg - NW'(1));
    always_comb
    begin
        unique case (rot_reg)
            2'd0:
            begin
                mi = row_reg;
                mj = col_reg;
            end
            2'd1:
            begin
                mi = nm1 - col_reg;
                mj = row_reg;
            end
            2'd2:
            begin
                mi = nm1 - row_reg;
                mj = nm1 - col_reg;
            end
            default:
            begin
                mi = col_reg;
                mj = nm1 - row_reg;
            end
        endcase
    end

    // A counter at or beyond the grid area is taken as zero where it is used
    assign mask_eff    = (TW'(mask_pos_reg) >= total_reg) ? '0 : mask_pos_reg;
    assign letter_eff  = (TW'(letter_pos_reg) >= total_reg) ? '0 : letter_pos_reg;
    assign rd_eff      = (TW'(rd_pos_reg) >= total_reg) ? '0 : rd_pos_reg;

    assign hole_idx    = AW'(TW'(mi) * TW'(n_reg) + TW'(mj));
    assign rd_wrap     = (TW'(rd_eff) + TW'(1)) >= total_reg;
    assign mask_wrap   = (TW'(mask_eff) + TW'(1)) >= total_reg;
    assign letter_wrap = (TW'(letter_eff) + TW'(1)) >= total_reg;
    assign col_wrap    = (NW'(col_reg) + NW'(1)) == n_reg;

    // Geometry update sequence and command handling
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        total_next      = total_reg;
        mask_pos_next   = mask_pos_reg;
        letter_pos_next = letter_pos_reg;
        rd_pos_next     = rd_pos_reg;
        rem_next        = rem_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        rot_next        = rot_reg;
        q_push          = 1'b0;
        op.kind         = OP_READ;
        op.hole_addr    = hole_idx;
        op.letter_addr  = rd_eff;
        op.data         = cmd_ch.cell_char;
        op.hole_bit     = (cmd_ch.cell_char == open_mark);
        op.last         = (rot_reg == 2'd3) && rd_wrap;

        unique case (state_reg)
            // clamp the edge length
            RS_SIZE:
            begin
                if (grid_size == '0)
                begin
                    n_next = NW'(1);
                end
                else if (32'(grid_size) > MAX_SIZE)
                begin
                    n_next = NW'(MAX_SIZE);
                end
                else
                begin
                    n_next = NW'(grid_size);
                end
                state_next = RS_AREA;
            end
            RS_AREA:
            begin
                total_next = TW'(n_reg) * TW'(n_reg);
                state_next = RS_FIT;
            end
            // split starts from the readout position as seen in the new grid
            RS_FIT:
            begin
                rem_next   = rd_eff;
                row_next   = '0;
                state_next = RS_DIV;
            end
            // split readout position into row and column, one row a cycle
            RS_DIV:
            begin
                if (TW'(rem_reg) >= TW'(n_reg))
                begin
                    rem_next = rem_reg - AW'(n_reg);
                    row_next = row_reg + IW'(1);
                end
                else
                begin
                    col_next   = IW'(rem_reg);
                    state_next = RS_RUN;
                end
            end
            RS_RUN:
            begin
                if (accept)
                begin
                    unique case (cmd_ch.cmd)
                        CMD_LOAD_MASK:
                        begin
                            q_push        = 1'b1;
                            op.kind       = OP_MASK;
                            op.hole_addr  = mask_eff;
                            mask_pos_next = mask_wrap ? '0 : mask_eff + AW'(1);
                        end
                        CMD_LOAD_LETTER:
                        begin
                            q_push          = 1'b1;
                            op.kind         = OP_LETTER;
                            op.letter_addr  = letter_eff;
                            letter_pos_next = letter_wrap ? '0 : letter_eff + AW'(1);
                        end
                        CMD_READOUT:
                        begin
                            q_push = 1'b1;
                            if (rd_wrap)
                            begin
                                rd_pos_next = '0;
                                row_next    = '0;
                                col_next    = '0;
                                rot_next    = rot_reg + 2'd1;
                            end
                            else
                            begin
                                rd_pos_next = rd_eff + AW'(1);
                                if (col_wrap)
                                begin
                                    col_next = '0;
                                    row_next = row_reg + IW'(1);
                                end
                                else
                                begin
                                    col_next = col_reg + IW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            q_push = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = RS_SIZE;
            end
        endcase

        // a new edge length restarts the geometry update
        if (grid_write)
        begin
            state_next = RS_SIZE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= RS_SIZE;
            n_reg          <= NW'(1);
            total_reg      <= TW'(1);
            mask_pos_reg   <= '0;
            letter_pos_reg <= '0;
            rd_pos_reg     <= '0;
            rem_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            rot_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            total_reg      <= total_next;
            mask_pos_reg   <= mask_pos_next;
            letter_pos_reg <= letter_pos_next;
            rd_pos_reg     <= rd_pos_next;
            rem_reg        <= rem_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            rot_reg        <= rot_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/tgd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tgd_back
// Executes queued operations against the hole map and letter grid and
// drives the result register.
// ----------------------------------------------------------------------------
module tgd_back
    import tgd_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEFAULT,
    localparam int CELLS = MAX_SIZE * MAX_SIZE,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int OPW = 2 * AW + OP_FIXED_W
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire logic [OPW-1:0] q_word,
    output logic                q_pop,
    tgd_res_if.source           res_ch
);

    typedef struct packed {
        op_kind_t          kind;
        logic [AW-1:0]     hole_addr;
        logic [AW-1:0]     letter_addr;
        logic [CHAR_W-1:0] data;
        logic              hole_bit;
        logic              last;
    } op_t;

    op_t               op;
    back_state_t       state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] letter_reg, letter_next;
    logic              letter_valid_reg, letter_valid_next;
    logic              done_reg, done_next;
    logic              last_reg, last_next;
    logic              hole_we, letter_we;
    logic              hole_rdata;
    logic [CHAR_W-1:0] letter_rdata;

    assign op = op_t'(q_word);

    // Hole flags, one bit per mask cell
    tgd_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_hole_ram (
        .clk   (clk),
        .we    (hole_we),
        .addr  (op.hole_addr),
        .wdata (op.hole_bit),
        .rdata (hole_rdata)
    );

    // Cipher letters
    tgd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_letter_ram (
        .clk   (clk),
        .we    (letter_we),
        .addr  (op.letter_addr),
        .wdata (op.data),
        .rdata (letter_rdata)
    );

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.letter       = letter_reg;
    assign res_ch.letter_valid = letter_valid_reg;
    assign res_ch.done_res     = done_reg;

    // Operation sequencer
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        letter_next       = letter_reg;
        letter_valid_next = letter_valid_reg;
        done_next         = done_reg;
        last_next         = last_reg;
        q_pop             = 1'b0;
        hole_we           = 1'b0;
        letter_we         = 1'b0;

        if (res_ch.valid && res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (op.kind)
                        OP_MASK:
                        begin
                            q_pop   = 1'b1;
                            hole_we = 1'b1;
                        end
                        OP_LETTER:
                        begin
                            q_pop     = 1'b1;
                            letter_we = 1'b1;
                        end
                        OP_READ:
                        begin
                            // start the read only with the result register free
                            if (!out_valid_reg)
                            begin
                                q_pop      = 1'b1;
                                last_next  = op.last;
                                state_next = BK_READ;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                out_valid_next    = 1'b1;
                letter_next       = hole_rdata ? letter_rdata : '0;
                letter_valid_next = hole_rdata;
                done_next         = last_reg;
                state_next        = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        letter_reg       <= letter_next;
        letter_valid_reg <= letter_valid_next;
        done_reg         <= done_next;
        last_reg         <= last_next;
    end

endmodule

`default_nettype wire

// ===== src/turning_grille_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// turning_grille_decoder_core
// Turning-grille decoder with an APB-style register port.
// ----------------------------------------------------------------------------
// Command words load the grille mask (cmd 0) and the cipher letters (cmd 1)
// in row-major order and step through the readout (cmd 2): four rotations,
// each row-major, one result word per step carrying the letter when the
// rotated mask cell is open, and done_res on the last position of the fourth
// rotation. Words wait in the operation queue, so while it has room the front
// takes a new word before the back end is through with the last. A readout
// step runs through the registered read of the letter and hole memories into
// the single result register, and starts only while that register is free.
// After reset and after every grid_size write the command port holds ready
// low while the front recomputes the grid area and splits the readout position
// into row and column.
// The memories are not cleared: read only cells that were loaded.
// ----------------------------------------------------------------------------
module turning_grille_decoder_core
    import tgd_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tgd_cmd_if.sink                    cmd_ch,
    tgd_res_if.source                  res_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int OPW = 2 * AW + OP_FIXED_W;

    logic [GRID_W-1:0] grid_size_reg, grid_size_next;
    logic [CHAR_W-1:0] open_mark_reg, open_mark_next;
    logic              cfg_write;
    logic              grid_write;
    logic              q_push, q_pop, q_full, q_empty;
    logic [OPW-1:0]    push_word, pop_word;

    // Register port
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign grid_write = cfg_write && (paddr[2] == REG_GRID_SIZE);

    always_comb
    begin
        grid_size_next = grid_size_reg;
        open_mark_next = open_mark_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GRID_SIZE: grid_size_next = pwdata[GRID_W-1:0];
                REG_OPEN_MARK: open_mark_next = pwdata[CHAR_W-1:0];
                default:       grid_size_next = grid_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GRID_SIZE: prdata = APB_DATA_W'(grid_size_reg);
            REG_OPEN_MARK: prdata = APB_DATA_W'(open_mark_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_RESET;
            open_mark_reg <= OPEN_MARK_RESET;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
            open_mark_reg <= open_mark_next;
        end
    end

    // Command front
    tgd_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .grid_size  (grid_size_reg),
        .open_mark  (open_mark_reg),
        .grid_write (grid_write),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (push_word)
    );

    // Operation queue
    tgd_queue #(
        .WIDTH (OPW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    // Memory back end
    tgd_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_word  (pop_word),
        .q_pop   (q_pop),
        .res_ch  (res_ch)
    );

endmodule

`default_nettype wire

// ===== test/turning_grille_decoder_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// turning_grille_decoder_core_test
// Self-checking testbench for the turning-grille decoder core.
// ----------------------------------------------------------------------------
// Words go in on the command channel under random source gaps and sink stalls.
// A behavioral model of the grille, the letter grid, the load counters and
// the readout walk predicts every result word. Each result word is checked
// against the oldest prediction. Register settings change only while the
// block is idle, and they cover clamped grid sizes and extreme open marks.
// Readout only starts once every cell that the current edge can touch has
// been loaded.
// ----------------------------------------------------------------------------
module turning_grille_decoder_core_test;
    import tgd_pkg::*;

    localparam int MAX_SIZE = MAX_SIZE_DEFAULT;
    localparam int CELLS    = MAX_SIZE * MAX_SIZE;
    localparam int DRAIN    = 16;
    localparam int LIMIT    = 1_000_000;

    localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] GRID_ADDR  = {REG_GRID_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] MARK_ADDR  = {REG_OPEN_MARK, 2'b00};

    typedef struct packed {
        logic [CHAR_W-1:0] letter;
        logic              letter_valid;
        logic              done_res;
    } decoded_pos_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tgd_cmd_if cmd_ch ();
    tgd_res_if res_ch ();

    turning_grille_decoder_core #(
        .MAX_SIZE (MAX_SIZE)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .res_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Grille model state
    bit                hole_open     [CELLS];
    bit                hole_loaded   [CELLS];
    logic [CHAR_W-1:0] letter_store  [CELLS];
    bit                letter_loaded [CELLS];
    int unsigned       hole_fill   = 0;
    int unsigned       letter_fill = 0;
    int unsigned       walk_pos    = 0;
    logic [1:0]        walk_turn   = 2'd0;
    logic [GRID_W-1:0] size_reg    = GRID_RESET;
    logic [CHAR_W-1:0] mark_reg    = OPEN_MARK_RESET;

    decoded_pos_t expected_positions[$];
    int           mismatch_count  = 0;

    // Idling controls
    bit source_gaps     = 1'b1;
    bit sink_stalls     = 1'b1;
    int hold_cycles_req = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void flag_mismatch(input string msg);
        if (mismatch_count < 10)
            $display("MISMATCH: %s", msg);
        mismatch_count++;
    endfunction

    // Effective edge length: 0 reads as 1, large values clamp
    function automatic int unsigned grille_edge();
        int unsigned n;
        n = 32'(size_reg);
        if (n == 0)
            n = 1;
        if (n > MAX_SIZE)
            n = MAX_SIZE;
        return n;
    endfunction

    function automatic bit grids_loaded();
        int unsigned total;
        total = grille_edge() * grille_edge();
        for (int unsigned k = 0; k < total; k++)
            if (!hole_loaded[k] || !letter_loaded[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit holes_loaded();
        int unsigned total;
        total = grille_edge() * grille_edge();
        for (int unsigned k = 0; k < total; k++)
            if (!hole_loaded[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Predict the effect of one accepted command word
    function automatic void decode_word(input logic [CMD_W-1:0] c,
                                        input logic [CHAR_W-1:0] ch);
        int unsigned  n;
        int unsigned  total;
        int unsigned  pos;
        int unsigned  i;
        int unsigned  j;
        int unsigned  mi;
        int unsigned  mj;
        decoded_pos_t want;
        n     = grille_edge();
        total = n * n;
        case (c)
            CMD_LOAD_MASK:
            begin
                pos = (hole_fill >= total) ? 0 : hole_fill;
                hole_open[pos]   = (ch == mark_reg);
                hole_loaded[pos] = 1'b1;
                pos++;
                hole_fill = (pos >= total) ? 0 : pos;
            end
            CMD_LOAD_LETTER:
            begin
                pos = (letter_fill >= total) ? 0 : letter_fill;
                letter_store[pos]  = ch;
                letter_loaded[pos] = 1'b1;
                pos++;
                letter_fill = (pos >= total) ? 0 : pos;
            end
            CMD_READOUT:
            begin
                pos = (walk_pos >= total) ? 0 : walk_pos;
                i   = pos / n;
                j   = pos % n;
                // mask cell seen through the grille after walk_turn clockwise turns
                case (walk_turn)
                    2'd0:
                    begin
                        mi = i;
                        mj = j;
                    end
                    2'd1:
                    begin
                        mi = n - 1 - j;
                        mj = i;
                    end
                    2'd2:
                    begin
                        mi = n - 1 - i;
                        mj = n - 1 - j;
                    end
                    default:
                    begin
                        mi = j;
                        mj = n - 1 - i;
                    end
                endcase
                want.letter_valid = hole_open[mi * n + mj];
                want.letter       = want.letter_valid ? letter_store[pos] : '0;
                want.done_res     = (walk_turn == 2'd3) && (pos + 1 == total);
                expected_positions.insert(expected_positions.size(), want);
                pos++;
                if (pos >= total)
                begin
                    pos       = 0;
                    walk_turn = walk_turn + 2'd1;
                end
                walk_pos = pos;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Random word; readout only once both grids cover the current edge
    function automatic void pick_word(output logic [CMD_W-1:0] c,
                                      output logic [CHAR_W-1:0] ch);
        int roll;
        roll = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        if (!grids_loaded())
        begin
            if (roll < 5)
                c = CMD_UNUSED;
            else if (holes_loaded())
                c = CMD_LOAD_LETTER;
            else if (grids_loaded() || roll < 55)
                c = CMD_LOAD_MASK;
            else
                c = CMD_LOAD_LETTER;
        end
        else if (roll < 62)
            c = CMD_READOUT;
        else if (roll < 76)
            c = CMD_LOAD_MASK;
        else if (roll < 92)
            c = CMD_LOAD_LETTER;
        else
            c = CMD_UNUSED;
        // about half the mask bytes open a hole
        if (c == CMD_LOAD_MASK && $urandom_range(0, 1) == 1)
            ch = mark_reg;
    endfunction

    // Offer one word and wait for it to be taken; valid stays high afterwards
    task automatic push_word(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c;
        cmd_ch.cell_char <= ch;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        decode_word(c, ch);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_positions.size() != 0);
    endtask

    // Each transfer ends with psel and penable dropped back to idle on the register port
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until idle, then write both registers with junk in the upper bits
    task automatic set_config(input logic [GRID_W-1:0] size, input logic [CHAR_W-1:0] mark);
        logic [APB_DATA_W-1:0] rd;
        drain_results();
        repeat (DRAIN) @(posedge clk);
        reg_write(GRID_ADDR, ($urandom & ~32'h1F) | APB_DATA_W'(size));
        size_reg = size;
        reg_read(GRID_ADDR, rd);
        if (rd[GRID_W-1:0] !== size)
            flag_mismatch($sformatf("grid_size readback exp=%0d act=%0d",
                                    size, rd[GRID_W-1:0]));
        reg_write(MARK_ADDR, ($urandom & ~32'hFF) | APB_DATA_W'(mark));
        mark_reg = mark;
        reg_read(MARK_ADDR, rd);
        if (rd[CHAR_W-1:0] !== mark)
            flag_mismatch($sformatf("open_mark readback exp=%0d act=%0d",
                                    mark, rd[CHAR_W-1:0]));
    endtask

    task automatic run_random_phase(input logic [GRID_W-1:0] size,
                                    input logic [CHAR_W-1:0] mark,
                                    input int count, input bit idling);
        logic [CMD_W-1:0]  c;
        logic [CHAR_W-1:0] ch;
        set_config(size, mark);
        source_gaps = idling;
        sink_stalls = idling;
        for (int k = 0; k < count; k++)
        begin
            // stretches with and without idling
            if (idling && k % 64 == 0)
            begin
                source_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            pick_word(c, ch);
            push_word(c, ch);
        end
    endtask

    // ---- test tasks ----

    task automatic test_register_reset();
        logic [APB_DATA_W-1:0] rd;
        reg_read(GRID_ADDR, rd);
        if (rd[GRID_W-1:0] !== GRID_RESET)
            flag_mismatch($sformatf("grid_size reset exp=%0d act=%0d",
                                    GRID_RESET, rd[GRID_W-1:0]));
        reg_read(MARK_ADDR, rd);
        if (rd[CHAR_W-1:0] !== OPEN_MARK_RESET)
            flag_mismatch($sformatf("open_mark reset exp=%0d act=%0d",
                                    OPEN_MARK_RESET, rd[CHAR_W-1:0]));
    endtask

    // Zero grid size acts as one cell: every readout is a full rotation
    task automatic test_single_cell();
        set_config('0, 8'hFF);
        push_word(CMD_LOAD_MASK, 8'hFF);
        push_word(CMD_LOAD_LETTER, 8'h00);
        push_word(CMD_UNUSED, 8'hFF);
        repeat (2)
        begin
            push_word(CMD_READOUT, 8'hFF);
            push_word(CMD_READOUT, 8'h00);
        end
        // loads wrap straight back to cell zero; a byte off the mark closes the hole
        push_word(CMD_LOAD_MASK, 8'h00);
        push_word(CMD_LOAD_LETTER, 8'hFF);
        push_word(CMD_LOAD_MASK, 8'hFE);
        repeat (4) push_word(CMD_READOUT, 8'hA5);
    endtask

    // Two by two grille with mark zero, letters at both extremes
    task automatic test_small_grille();
        set_config(5'd2, 8'h00);
        push_word(CMD_LOAD_MASK, 8'h00);
        push_word(CMD_LOAD_MASK, 8'hFF);
        push_word(CMD_LOAD_MASK, 8'h4F);
        push_word(CMD_LOAD_MASK, 8'h00);
        push_word(CMD_LOAD_LETTER, 8'hFF);
        push_word(CMD_LOAD_LETTER, 8'h01);
        push_word(CMD_LOAD_LETTER, 8'h80);
        push_word(CMD_LOAD_LETTER, 8'h7F);
        repeat (6) push_word(CMD_READOUT, 8'h00);
    endtask

    task automatic test_random_settings();
        run_random_phase(GRID_RESET, OPEN_MARK_RESET, 200, 1'b1);
        run_random_phase(5'd16, 8'h00, 530, 1'b1);
        run_random_phase(5'd3, CHAR_W'($urandom_range(0, 255)), 150, 1'b1);
        run_random_phase(5'd31, 8'hFF, 80, 1'b1);
        run_random_phase(5'd2, 8'hFF, 120, 1'b1);
        run_random_phase(5'd7, CHAR_W'($urandom_range(0, 255)), 200, 1'b1);
        run_random_phase(5'd17, CHAR_W'($urandom_range(0, 255)), 60, 1'b1);
        run_random_phase(5'd5, OPEN_MARK_RESET, 150, 1'b1);
    endtask

    // Long sink hold fills the block; then random sink stalls with no source gaps
    task automatic test_backpressure();
        logic [CMD_W-1:0]  c;
        logic [CHAR_W-1:0] ch;
        set_config(GRID_RESET, OPEN_MARK_RESET);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        while (!grids_loaded())
        begin
            pick_word(c, ch);
            push_word(c, ch);
        end
        hold_cycles_req = 150;
        repeat (40) push_word(CMD_READOUT, CHAR_W'($urandom_range(0, 255)));
        drain_results();
        sink_stalls = 1'b1;
        repeat (40)
        begin
            pick_word(c, ch);
            push_word(c, ch);
        end
    endtask

    task automatic test_streaming_tail();
        run_random_phase(5'd6, CHAR_W'($urandom_range(0, 255)), 150, 1'b0);
    endtask

    // Result sink: random stall bursts plus requested long holds
    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req > 0)
            begin
                stall_left      = hold_cycles_req;
                hold_cycles_req = 0;
            end
            else if (stall_left == 0 && sink_stalls && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        decoded_pos_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_positions.size() == 0)
                flag_mismatch($sformatf("unexpected word letter=%0h lv=%0b done=%0b",
                                        res_ch.letter, res_ch.letter_valid,
                                        res_ch.done_res));
            else
            begin
                want = expected_positions.pop_front();
                if (res_ch.letter !== want.letter || res_ch.letter_valid !== want.letter_valid
                    || res_ch.done_res !== want.done_res)
                    flag_mismatch($sformatf(
                        "letter exp=%0h act=%0h lv exp=%0b act=%0b done exp=%0b act=%0b",
                        want.letter, res_ch.letter, want.letter_valid, res_ch.letter_valid,
                        want.done_res, res_ch.done_res));
            end
        end
    end

    // Watchdog
    initial
    begin
        #(LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= CMD_LOAD_MASK;
        cmd_ch.cell_char <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_single_cell();
        test_small_grille();
        test_random_settings();
        test_backpressure();
        test_streaming_tail();

        drain_results();
        repeat (DRAIN) @(posedge clk);
        if (expected_positions.size() != 0)
            flag_mismatch($sformatf("%0d result words never arrived",
                                    expected_positions.size()));
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== turning_grille_decoder_core.f =====
src/tgd_pkg.sv
src/tgd_cmd_if.sv
src/tgd_res_if.sv
src/tgd_ram.sv
src/tgd_queue.sv
src/tgd_front.sv
src/tgd_back.sv
src/turning_grille_decoder_core.sv
test/turning_grille_decoder_core_test.sv
